@@ rtl/ssto_pkg.sv @@
package ssto_pkg;

    // Default sizes; the table depth and phase width are also the top-level defaults.
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int PHASE_BITS       = 32;
    localparam int QUEUE_DEPTH      = 2;

    // Field widths.
    localparam int FREQ_W   = 16;
    localparam int PEAK_W   = 15;
    localparam int RATE_W   = 17;
    localparam int SAMPLE_W = 16;

    localparam logic [RATE_W-1:0] RATE_RESET = 17'd22050;

    // Full-scale amplitude is 2^15 - 1.
    localparam logic [15:0] PEAK_FULL  = 16'd32767;
    localparam int          PEAK_SHIFT = 15;

    // pi/2 in Q30, the argument scale of the table builder.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // A tone command as it travels from the front to the back through the queue.
    typedef struct packed {
        logic              start;
        logic              silent;
        logic              square;
        logic [PEAK_W-1:0] peak;
        logic [RATE_W-1:0] period;
    } tone_cmd_t;

endpackage

@@ rtl/ssto_if.sv @@
interface ssto_in_if;
    logic                          valid;
    logic                          ready;
    logic                          tone_start;
    logic [ssto_pkg::FREQ_W-1:0]   freq_hz;
    logic [ssto_pkg::PEAK_W-1:0]   peak_level;
    logic                          square_wave;

    modport source (
        output valid, tone_start, freq_hz, peak_level, square_wave,
        input  ready
    );
    modport sink (
        input  valid, tone_start, freq_hz, peak_level, square_wave,
        output ready
    );
endinterface

interface ssto_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ssto_pkg::SAMPLE_W-1:0] sample;

    modport source (
        output valid, sample,
        input  ready
    );
    modport sink (
        input  valid, sample,
        output ready
    );
endinterface

@@ rtl/sine_square_tone_oscillator_top.sv @@
// Channel   Direction  Payload                                        Beat when
// tone      in         tone_start, freq_hz, peak_level, square_wave   valid && ready
// audio     out        sample (signed 16 bits)                        valid && ready
// cfg       in         cfg_wdata (sample rate, 17 bits)               cfg_we high
//
// A beat without tone start, or one whose frequency is zero, passes straight through
// the front, so plain samples stream at one per cycle while the queue has room.
// A tone start with a non-zero frequency holds the input until both dividers finish:
// the phase-step divider resolves one quotient bit per cycle over PHASE_BITS + 16 bits.
// A sample reaches audio through registers in order: its beat is queued first, then
// the table read, the multiply and the divide-and-sign each end in a register, and
// the output beat can be taken from the last of them.
// Reset clears all control state at once; the sine table is constant, so no clearing pass.
// A stall on audio freezes the three back stages; the two-entry queue keeps
// accepting until it fills, and the front then drops ready.

module sine_square_tone_oscillator_top #(
    parameter int SINE_TABLE_DEPTH = ssto_pkg::SINE_TABLE_DEPTH,
    parameter int PHASE_BITS       = ssto_pkg::PHASE_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ssto_in_if.sink                     tone,
    ssto_out_if.source                  audio,
    input  logic                        cfg_we,
    input  logic [ssto_pkg::RATE_W-1:0] cfg_wdata
);

    // The queue carries one tone command plus its phase step per entry.
    localparam int CMD_W  = $bits(ssto_pkg::tone_cmd_t);
    localparam int QW     = CMD_W + PHASE_BITS;

    logic                  push_valid;
    logic                  push_ready;
    ssto_pkg::tone_cmd_t   push_cmd;
    logic [PHASE_BITS-1:0] push_step;
    logic                  pop_valid;
    logic                  pop_ready;
    logic [QW-1:0]         pop_data;
    ssto_pkg::tone_cmd_t   pop_cmd;
    logic [PHASE_BITS-1:0] pop_step;

    // The front takes input beats, runs the dividers on a tone start with a non-zero
    // frequency and turns each beat into a command.
    ssto_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tone       (tone),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .push_step  (push_step)
    );

    // The queue decouples the dividers from the sample pipeline.
    ssto_fifo #(
        .WIDTH (QW),
        .DEPTH (ssto_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_cmd, push_step}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_cmd  = ssto_pkg::tone_cmd_t'(pop_data[QW-1 -: CMD_W]);
    assign pop_step = pop_data[PHASE_BITS-1:0];

    // The back owns the phase accumulator and square position and produces
    // one sample per command.
    ssto_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .pop_step   (pop_step),
        .audio      (audio)
    );

endmodule

@@ rtl/ssto_div.sv @@
module ssto_div #(
    parameter int DVD_W = 48,
    parameter int DVS_W = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] count_reg;
    logic [DVD_W-1:0] shift_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] div_reg;
    logic [DVS_W:0]   rem_shift;
    logic [DVS_W:0]   rem_next;
    logic             fits;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // at the top of shift_reg while quotient bits enter at the bottom.
    always_comb
    begin
        rem_shift = {rem_reg, shift_reg[DVD_W-1]};
        fits      = rem_shift >= {1'b0, div_reg};
        rem_next  = fits ? (rem_shift - {1'b0, div_reg}) : rem_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (start)
        begin
            count_reg <= CNT_W'(DVD_W);
        end
        else if (count_reg != '0)
        begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            div_reg   <= divisor;
        end
        else if (count_reg != '0)
        begin
            rem_reg   <= rem_next[DVS_W-1:0];
            shift_reg <= {shift_reg[DVD_W-2:0], fits};
        end
    end

    assign busy     = count_reg != '0;
    assign quotient = shift_reg;

endmodule

@@ rtl/ssto_front.sv @@
module ssto_front #(
    parameter int PHASE_BITS = ssto_pkg::PHASE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ssto_in_if.sink                       tone,
    input  logic                          cfg_we,
    input  logic [ssto_pkg::RATE_W-1:0]   cfg_wdata,
    output logic                          push_valid,
    input  logic                          push_ready,
    output ssto_pkg::tone_cmd_t           push_cmd,
    output logic [PHASE_BITS-1:0]         push_step
);

    localparam int FW         = ssto_pkg::FREQ_W;
    localparam int RW         = ssto_pkg::RATE_W;
    localparam int PW         = ssto_pkg::PEAK_W;
    localparam int STEP_DVD_W = PHASE_BITS + FW;

    typedef enum logic {
        S_IDLE,
        S_DIV
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [RW-1:0]         rate_reg;
    logic [RW-1:0]         rate_eff;
    logic [RW-1:0]         rate_used_reg;
    logic [FW-1:0]         f_sat;
    logic [FW-1:0]         f_sat_reg;
    logic [PW-1:0]         held_peak_reg;
    logic                  held_square_reg;
    logic                  accept;
    logic                  div_go;
    logic                  step_busy;
    logic                  period_busy;
    logic [STEP_DVD_W-1:0] step_quot;
    logic [RW-1:0]         period_quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= ssto_pkg::RATE_RESET;
        end
        else if (cfg_we)
        begin
            rate_reg <= cfg_wdata;
        end
    end

    // A zero rate counts as one; the frequency saturates at the rate.
    assign rate_eff = (rate_reg == '0) ? RW'(1) : rate_reg;
    assign f_sat    = ({1'b0, tone.freq_hz} > rate_eff) ? rate_eff[FW-1:0]
                                                       : tone.freq_hz;

    assign tone.ready = (state_reg == S_IDLE) && push_ready;
    assign accept     = tone.valid && tone.ready;
    assign div_go     = accept && tone.tone_start && (f_sat != '0);

    ssto_div #(
        .DVD_W (STEP_DVD_W),
        .DVS_W (RW)
    ) u_step_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend ({f_sat, {PHASE_BITS{1'b0}}}),
        .divisor  (rate_eff),
        .busy     (step_busy),
        .quotient (step_quot)
    );

    ssto_div #(
        .DVD_W (RW),
        .DVS_W (FW)
    ) u_period_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (rate_eff),
        .divisor  (f_sat),
        .busy     (period_busy),
        .quotient (period_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        push_valid = 1'b0;
        push_cmd   = '0;
        push_step  = '0;
        case (state_reg)
            S_IDLE:
            begin
                // Plain beats and silent tone starts go straight to the queue.
                push_valid      = accept && !div_go;
                push_cmd.start  = tone.tone_start;
                push_cmd.silent = 1'b1;
                push_cmd.square = tone.square_wave;
                push_cmd.peak   = tone.peak_level;
                if (div_go)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                push_valid      = !step_busy && !period_busy;
                push_cmd.start  = 1'b1;
                push_cmd.silent = 1'b0;
                push_cmd.square = held_square_reg;
                push_cmd.peak   = held_peak_reg;
                push_cmd.period = period_quot;
                // A step of exactly 2^PHASE_BITS wraps to zero here.
                push_step       = step_quot[PHASE_BITS-1:0];
                if (push_valid && push_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            held_peak_reg   <= '0;
            held_square_reg <= 1'b0;
            f_sat_reg       <= '0;
            rate_used_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_go)
            begin
                held_peak_reg   <= tone.peak_level;
                held_square_reg <= tone.square_wave;
                f_sat_reg       <= f_sat;
                rate_used_reg   <= rate_eff;
            end
        end
    end

    // The square period handed on must be the floor of rate over frequency.
    a_period_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && push_valid && push_ready) |->
            ((34'(period_quot) * 34'(f_sat_reg) <= 34'(rate_used_reg)) &&
             ((34'(period_quot) + 34'(1)) * 34'(f_sat_reg) > 34'(rate_used_reg))))
        else $error("square period is not the quotient of rate and frequency");

endmodule

@@ rtl/ssto_fifo.sv @@
module ssto_fifo #(
    parameter int WIDTH = 40,
    parameter int DEPTH = ssto_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    // DEPTH must be a power of two, at least two, so the pointers wrap on their own; not checked here.
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != (AW + 1)'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (AW + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW + 1)'(DEPTH))
        else $error("queue fill count beyond its depth");

endmodule

@@ rtl/ssto_back.sv @@
module ssto_back #(
    parameter int SINE_TABLE_DEPTH = ssto_pkg::SINE_TABLE_DEPTH,
    parameter int PHASE_BITS       = ssto_pkg::PHASE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  ssto_pkg::tone_cmd_t   pop_cmd,
    input  logic [PHASE_BITS-1:0] pop_step,
    ssto_out_if.source            audio
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int RW = ssto_pkg::RATE_W;
    localparam int PW = ssto_pkg::PEAK_W;
    localparam int SW = ssto_pkg::SAMPLE_W;
    localparam int XW = SW + PW;

    typedef logic [15:0] rom_t [SINE_TABLE_DEPTH];

    // Quarter-wave entry from a fixed-point Taylor series to x^11, Q30 argument.
    function automatic logic [15:0] sine_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = (64'(k) * ssto_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        r    = (sum * 64'(ssto_pkg::PEAK_FULL) + (64'd1 << 29)) >> 30;
        if (r > 64'(ssto_pkg::PEAK_FULL))
        begin
            r = 64'(ssto_pkg::PEAK_FULL);
        end
        return r[15:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t tbl;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            tbl[k] = sine_entry(k);
        end
        return tbl;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Tone state.
    logic                  silent_reg;
    logic                  square_reg;
    logic [PW-1:0]         peak_reg;
    logic [PHASE_BITS-1:0] step_reg;
    logic [RW-1:0]         period_reg;
    logic [PHASE_BITS-1:0] acc_reg;
    logic [RW-1:0]         pos_reg;

    // Stage 0 decode.
    logic                  cur_silent;
    logic                  cur_square;
    logic [PW-1:0]         cur_peak;
    logic [PHASE_BITS-1:0] cur_step;
    logic [RW-1:0]         cur_period;
    logic [PHASE_BITS-1:0] cur_acc;
    logic [RW-1:0]         cur_pos;
    logic [PHASE_BITS-1:0] acc_next;
    logic [RW-1:0]         pos_next;
    logic [RW:0]           pos_inc;
    logic [1:0]            quad;
    logic [AW-1:0]         off;
    logic [AW-1:0]         rom_addr;
    logic                  full_mag;
    logic                  sq_pos;

    // Pipeline registers.
    logic                  adv;
    logic                  take;
    logic                  a_valid_reg;
    logic                  a_silent_reg;
    logic                  a_square_reg;
    logic                  a_pos_reg;
    logic                  a_neg_reg;
    logic                  a_full_reg;
    logic [PW-1:0]         a_peak_reg;
    logic [15:0]           rom_data_reg;
    logic                  b_valid_reg;
    logic                  b_silent_reg;
    logic                  b_square_reg;
    logic                  b_pos_reg;
    logic                  b_neg_reg;
    logic [PW-1:0]         b_peak_reg;
    logic [XW-1:0]         product_reg;
    logic                  out_valid_reg;
    logic [SW-1:0]         sample_reg;

    // Stage 2 arithmetic.
    logic [15:0]           rom_mag;
    logic [XW:0]           p_sum;
    logic [SW:0]           q_est;
    logic [XW:0]           q_times;
    logic [XW:0]           p_rem;
    logic [SW-1:0]         mag;
    logic [SW-1:0]         peak_ext;
    logic [SW-1:0]         value;

    assign adv       = !out_valid_reg || audio.ready;
    assign pop_ready = adv;
    assign take      = pop_valid && adv;

    always_comb
    begin
        if (pop_cmd.start)
        begin
            cur_silent = pop_cmd.silent;
            cur_square = pop_cmd.square;
            cur_peak   = pop_cmd.peak;
            cur_step   = pop_step;
            cur_period = pop_cmd.period;
            cur_acc    = '0;
            cur_pos    = '0;
        end
        else
        begin
            cur_silent = silent_reg;
            cur_square = square_reg;
            cur_peak   = peak_reg;
            cur_step   = step_reg;
            cur_period = period_reg;
            cur_acc    = acc_reg;
            cur_pos    = pos_reg;
        end

        quad     = cur_acc[PHASE_BITS-1 -: 2];
        off      = cur_acc[PHASE_BITS-3 -: AW];
        full_mag = quad[0] && (off == '0);
        rom_addr = quad[0] ? AW'((AW + 1)'(SINE_TABLE_DEPTH) - {1'b0, off}) : off;
        sq_pos   = cur_pos < (cur_period >> 1);
        pos_inc  = {1'b0, cur_pos} + (RW + 1)'(1);

        acc_next = cur_acc;
        pos_next = cur_pos;
        if (!cur_silent)
        begin
            if (cur_square)
            begin
                pos_next = (pos_inc >= {1'b0, cur_period}) ? '0 : pos_inc[RW-1:0];
            end
            else
            begin
                acc_next = cur_acc + cur_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silent_reg <= 1'b1;
            square_reg <= 1'b0;
            peak_reg   <= '0;
            step_reg   <= '0;
            period_reg <= '0;
            acc_reg    <= '0;
            pos_reg    <= '0;
        end
        else if (take)
        begin
            silent_reg <= cur_silent;
            square_reg <= cur_square;
            peak_reg   <= cur_peak;
            step_reg   <= cur_step;
            period_reg <= cur_period;
            acc_reg    <= acc_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= pop_valid;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    // Stage 2: divide by 2^15 - 1 with a reciprocal estimate and one correction.
    always_comb
    begin
        rom_mag  = a_full_reg ? ssto_pkg::PEAK_FULL : rom_data_reg;
        p_sum    = {1'b0, product_reg} + (XW + 1)'(product_reg >> ssto_pkg::PEAK_SHIFT);
        q_est    = (SW + 1)'(p_sum >> ssto_pkg::PEAK_SHIFT);
        q_times  = ((XW + 1)'(q_est) << ssto_pkg::PEAK_SHIFT) - (XW + 1)'(q_est);
        p_rem    = {1'b0, product_reg} - q_times;
        mag      = (p_rem >= (XW + 1)'(ssto_pkg::PEAK_FULL)) ? SW'(q_est + (SW + 1)'(1))
                                                             : SW'(q_est);
        peak_ext = {1'b0, b_peak_reg};
        if (b_silent_reg)
        begin
            value = '0;
        end
        else if (b_square_reg)
        begin
            value = b_pos_reg ? peak_ext : (~peak_ext + SW'(1));
        end
        else
        begin
            value = b_neg_reg ? (~mag + SW'(1)) : mag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_silent_reg <= cur_silent;
            a_square_reg <= cur_square;
            a_pos_reg    <= sq_pos;
            a_neg_reg    <= quad[1];
            a_full_reg   <= full_mag;
            a_peak_reg   <= cur_peak;
            rom_data_reg <= SINE_ROM[rom_addr];

            b_silent_reg <= a_silent_reg;
            b_square_reg <= a_square_reg;
            b_pos_reg    <= a_pos_reg;
            b_neg_reg    <= a_neg_reg;
            b_peak_reg   <= a_peak_reg;
            product_reg  <= XW'(rom_mag) * XW'(a_peak_reg);

            sample_reg   <= value;
        end
    end

    assign audio.valid  = out_valid_reg;
    assign audio.sample = $signed(sample_reg);

    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && b_valid_reg && b_silent_reg) |=> (out_valid_reg && sample_reg == '0))
        else $error("silent beat produced a non-zero sample");

    a_sine_within_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !b_silent_reg && !b_square_reg) |-> (mag <= peak_ext))
        else $error("scaled sine magnitude exceeds the held peak");

    a_no_most_negative: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (sample_reg != {1'b1, {(SW - 1){1'b0}}}))
        else $error("sample reached the most negative code");

endmodule

@@ test/tb_sine_square_tone_oscillator_top.sv @@
`timescale 1ns / 100ps

module tb_sine_square_tone_oscillator_top;

    // One beat on the tone input, as the sender offers it.
    typedef struct packed {
        logic                        start;
        logic [ssto_pkg::FREQ_W-1:0] freq;
        logic [ssto_pkg::PEAK_W-1:0] peak;
        logic                        square;
    } tone_beat_t;

    localparam longint unsigned PHASE_MASK = (64'd1 << ssto_pkg::PHASE_BITS) - 64'd1;
    localparam int              LONG_STALL = 400;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [ssto_pkg::RATE_W-1:0]   cfg_wdata;

    ssto_in_if  tone_bus ();
    ssto_out_if sample_bus ();

    sine_square_tone_oscillator_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tone       (tone_bus),
        .audio      (sample_bus),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    // Beats waiting to be offered, and the samples the oscillator owes us, oldest first.
    tone_beat_t  pending_beats[$];
    logic [15:0] owed_samples[$];

    int unsigned beats_queued;
    int unsigned beats_accepted;
    int unsigned error_count;
    logic        in_beat_seen;

    // Idling percentages for the sender and the receiver, set per phase.
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;

    // The stimulus process asks for a long receiver hold-off by bumping the request
    // count; the receiver process notices the difference and runs the hold-off itself.
    int unsigned stall_requests;
    int unsigned stall_acks;
    int unsigned hold_left;

    // Our own copy of the oscillator state, stepped once per accepted input beat.
    logic [ssto_pkg::RATE_W-1:0] rate_reg;
    longint unsigned             osc_phase;
    longint unsigned             osc_step;
    int unsigned                 sq_period;
    int unsigned                 sq_pos;
    logic [ssto_pkg::PEAK_W-1:0] tone_peak;
    logic                        tone_square;
    logic                        tone_mute;
    logic [15:0]                 quarter_sine [ssto_pkg::SINE_TABLE_DEPTH];

    // Quarter-wave table entry: fixed-point Taylor series in Q30 up to the x^11 term,
    // truncating at each step and rounding half up at the end.
    function automatic logic [15:0] taylor_sine(int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned r;
        longint unsigned kk;
        int unsigned     n;
        kk   = 64'(k);
        x    = (kk * ssto_pkg::HALF_PI_Q30) / ssto_pkg::SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (n = 1; n <= 5; n++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        r = (sum * ssto_pkg::PEAK_FULL + (64'd1 << 29)) >> 30;
        if (r > ssto_pkg::PEAK_FULL)
            r = ssto_pkg::PEAK_FULL;
        return r[15:0];
    endfunction

    // Works out the sample that one accepted beat produces, and advances the state.
    function automatic logic [15:0] predict_sample(tone_beat_t b);
        longint unsigned rate;
        longint unsigned f;
        longint unsigned idx;
        int unsigned     quad;
        int unsigned     off;
        int unsigned     s;
        int unsigned     mag;
        logic [15:0]     value;
        value = '0;
        if (b.start)
        begin
            // A rate of zero behaves as a rate of one; frequencies saturate to the rate.
            rate        = (rate_reg == 0) ? 64'd1 : 64'(rate_reg);
            f           = (64'(b.freq) > rate) ? rate : 64'(b.freq);
            tone_peak   = b.peak;
            tone_square = b.square;
            osc_phase   = 0;
            sq_pos      = 0;
            if (f == 0)
            begin
                tone_mute = 1'b1;
                osc_step  = 0;
                sq_period = 0;
            end
            else
            begin
                tone_mute = 1'b0;
                osc_step  = ((f << ssto_pkg::PHASE_BITS) / rate) & PHASE_MASK;
                sq_period = 32'(rate / f);
            end
        end
        if (!tone_mute)
        begin
            if (tone_square)
            begin
                if (sq_pos < sq_period / 2)
                    value = {1'b0, tone_peak};
                else
                    value = ~{1'b0, tone_peak} + 16'd1;
                sq_pos = (sq_pos + 1 >= sq_period) ? 0 : sq_pos + 1;
            end
            else
            begin
                idx  = (osc_phase * (4 * ssto_pkg::SINE_TABLE_DEPTH)) >> ssto_pkg::PHASE_BITS;
                quad = 32'((idx / ssto_pkg::SINE_TABLE_DEPTH) % 4);
                off  = 32'(idx % ssto_pkg::SINE_TABLE_DEPTH);
                if (quad % 2 == 1)
                    s = (off == 0) ? ssto_pkg::PEAK_FULL
                                   : quarter_sine[ssto_pkg::SINE_TABLE_DEPTH - off];
                else
                    s = quarter_sine[off];
                mag = (s * tone_peak) / ssto_pkg::PEAK_FULL;
                if (quad >= 2)
                    value = ~mag[15:0] + 16'd1;
                else
                    value = mag[15:0];
                osc_phase = (osc_phase + osc_step) & PHASE_MASK;
            end
        end
        return value;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic queue_beat(logic start, logic [ssto_pkg::FREQ_W-1:0] freq,
                              logic [ssto_pkg::PEAK_W-1:0] peak, logic square);
        tone_beat_t b;
        b = '{start: start, freq: freq, peak: peak, square: square};
        pending_beats.insert(pending_beats.size(), b);
        beats_queued++;
    endtask

    // A beat that carries no tone start; its fields should be ignored by the block.
    task automatic queue_carry_on();
        queue_beat(1'b0, ssto_pkg::FREQ_W'($urandom), ssto_pkg::PEAK_W'($urandom),
                   1'($urandom));
    endtask

    task automatic write_rate(logic [ssto_pkg::RATE_W-1:0] r);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(negedge clk);
        cfg_we    <= 1'b0;
        rate_reg   = r;
    endtask

    // Waits until every queued beat has been taken and every owed sample has come out.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (beats_accepted != beats_queued || owed_samples.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    // Random tones: mostly a tone start followed by a run of plain beats so that the
    // phase and square position get well into their cycles, with some noise beats.
    task automatic queue_tone_runs(int unsigned count);
        int unsigned                 pushed;
        int unsigned                 run;
        int unsigned                 pick;
        logic [ssto_pkg::FREQ_W-1:0] freq;
        logic [ssto_pkg::PEAK_W-1:0] peak;
        pushed = 0;
        // The tone left over from the previous phase carries on under the new rate.
        run = $urandom_range(1, 3);
        repeat (run) queue_carry_on();
        pushed += run;
        while (pushed < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                queue_beat(1'($urandom), ssto_pkg::FREQ_W'($urandom),
                           ssto_pkg::PEAK_W'($urandom), 1'($urandom));
                pushed++;
            end
            else
            begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       freq = '0;
                    1:       freq = $urandom_range(0, 1) ? 16'hFFFF
                                                         : ssto_pkg::FREQ_W'(rate_reg);
                    2, 3:    freq = ssto_pkg::FREQ_W'($urandom_range(1, 200));
                    4, 5:    freq = ssto_pkg::FREQ_W'($urandom_range(1, 4000));
                    6:       freq = ssto_pkg::FREQ_W'(rate_reg / $urandom_range(2, 16));
                    default: freq = ssto_pkg::FREQ_W'($urandom);
                endcase
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    peak = '0;
                else if (pick == 1)
                    peak = '1;
                else
                    peak = ssto_pkg::PEAK_W'($urandom);
                queue_beat(1'b1, freq, peak, 1'($urandom));
                run = $urandom_range(0, 40);
                repeat (run) queue_carry_on();
                pushed += run + 1;
            end
        end
    endtask

    // Short directed opening at the reset rate of 22050 Hz.
    task automatic queue_directed();
        // Silence straight after reset, with every field at its top value.
        queue_beat(1'b0, 16'hFFFF, 15'h7FFF, 1'b1);
        // A full-scale sine at 1 kHz, then plain beats whose fields must be ignored.
        queue_beat(1'b1, 16'd1000, 15'h7FFF, 1'b0);
        repeat (3) queue_carry_on();
        // A square wave of period five: two beats high, three low, then round again.
        queue_beat(1'b1, 16'd4410, 15'h7FFF, 1'b1);
        repeat (6) queue_carry_on();
        // Frequency zero is silence whatever the waveform.
        queue_beat(1'b1, 16'd0, 15'h7FFF, 1'b1);
        queue_carry_on();
        // Above the rate: the sine step wraps to zero, the square sits at minus peak.
        queue_beat(1'b1, 16'hFFFF, 15'h7FFF, 1'b0);
        queue_carry_on();
        queue_beat(1'b1, 16'hFFFF, 15'h7FFF, 1'b1);
        queue_carry_on();
        // Frequency equal to the rate with a zero peak, and the lowest sine frequency.
        queue_beat(1'b1, 16'd22050, 15'd0, 1'b1);
        queue_beat(1'b1, 16'd1, 15'd0, 1'b0);
        // Near a quarter of the rate the phase steps through every quadrant.
        queue_beat(1'b1, 16'd5512, 15'h7FFF, 1'b0);
        repeat (4) queue_carry_on();
    endtask

    always #1 clk = ~clk;

    // Sender: a beat stays on the bus until a rising edge sees it taken; the next one
    // is put up, or the bus goes idle, at the following falling edge.
    always @(negedge clk)
    begin : feed_tones
        tone_beat_t b;
        if (!tone_bus.valid || in_beat_seen)
        begin
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                b = pending_beats.pop_front();
                tone_bus.valid       <= 1'b1;
                tone_bus.tone_start  <= b.start;
                tone_bus.freq_hz     <= b.freq;
                tone_bus.peak_level  <= b.peak;
                tone_bus.square_wave <= b.square;
            end
            else
            begin
                tone_bus.valid <= 1'b0;
            end
        end
    end

    // Receiver: random ready, or a long hold-off when one has been asked for.
    always @(negedge clk)
    begin : drive_ready
        logic rdy;
        if (stall_acks != stall_requests)
        begin
            stall_acks <= stall_requests;
            hold_left  <= LONG_STALL;
            rdy         = 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rdy        = 1'b0;
        end
        else
        begin
            rdy = ($urandom_range(0, 99) >= snk_idle_pct);
        end
        sample_bus.ready <= rdy;
    end

    // Monitor: checks each output beat against the oldest owed sample, and predicts a
    // sample for each input beat taken at the same edge.
    always @(posedge clk)
    begin : watch_beats
        logic [15:0] want;
        logic [15:0] guess;
        tone_beat_t  seen;
        if (sample_bus.valid === 1'b1 && sample_bus.ready)
        begin
            if (owed_samples.size() == 0)
            begin
                flag_mismatch($sformatf("sample %0d with nothing owed",
                                        $signed(sample_bus.sample)));
            end
            else
            begin
                want = owed_samples.pop_front();
                if (sample_bus.sample !== want)
                    flag_mismatch($sformatf("sample %0d, predicted %0d",
                                            $signed(sample_bus.sample), $signed(want)));
            end
        end
        in_beat_seen <= (tone_bus.valid && tone_bus.ready === 1'b1);
        if (tone_bus.valid && tone_bus.ready === 1'b1)
        begin
            seen  = '{start: tone_bus.tone_start,
                      freq: tone_bus.freq_hz,
                      peak: tone_bus.peak_level,
                      square: tone_bus.square_wave};
            guess = predict_sample(seen);
            owed_samples.insert(owed_samples.size(), guess);
            beats_accepted++;
        end
    end

    // Main sequence: reset, the directed opening, then one random phase per rate.
    initial
    begin : run_phases
        logic [ssto_pkg::RATE_W-1:0] rates [7];
        int unsigned                 ph;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        tone_bus.valid       = 1'b0;
        tone_bus.tone_start  = 1'b0;
        tone_bus.freq_hz     = '0;
        tone_bus.peak_level  = '0;
        tone_bus.square_wave = 1'b0;
        sample_bus.ready     = 1'b0;
        in_beat_seen         = 1'b0;
        beats_queued         = 0;
        beats_accepted       = 0;
        error_count          = 0;
        stall_requests       = 0;
        stall_acks           = 0;
        hold_left            = 0;
        // Sender idles now and then, receiver most of the time, to begin with.
        src_idle_pct         = 21;
        snk_idle_pct         = 67;
        rate_reg             = ssto_pkg::RATE_RESET;
        osc_phase            = 0;
        osc_step             = 0;
        sq_period            = 0;
        sq_pos               = 0;
        tone_peak            = '0;
        tone_square          = 1'b0;
        tone_mute            = 1'b1;
        for (int k = 0; k < ssto_pkg::SINE_TABLE_DEPTH; k++)
            quarter_sine[k] = taylor_sine(k);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        @(posedge clk);
        queue_directed();
        wait_drained();

        // The field extremes, zero and all ones, sit among the usual audio rates.
        rates[0] = 17'd8000;
        rates[1] = 17'd96000;
        rates[2] = 17'd0;
        rates[3] = 17'h1FFFF;
        rates[4] = 17'd44100;
        rates[5] = 17'd11025;
        rates[6] = ssto_pkg::RATE_W'($urandom_range(8000, 96000));

        for (ph = 0; ph < 7; ph++)
        begin
            write_rate(rates[ph]);
            @(posedge clk);
            // Idling swaps round half way through, and the last phases run flat out.
            if (ph == 3)
            begin
                src_idle_pct = 67;
                snk_idle_pct = 21;
            end
            else if (ph == 5)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            // A long receiver hold-off while the sender keeps offering beats.
            if (ph == 1 || ph == 5)
                stall_requests++;
            queue_tone_runs(85);
            // The sequence waits here until every beat is taken and every owed sample has come out.
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin : watchdog
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
